[hw/rtl/markdown_line_tokenizer_core_defines.svh]
// assertion helpers for the tokenizer core
`ifndef MARKDOWN_LINE_TOKENIZER_CORE_DEFINES_SVH
`define MARKDOWN_LINE_TOKENIZER_CORE_DEFINES_SVH

// condition that holds at every edge out of reset
`define MDTOK_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define MDTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mdtok_pkg.sv]
package mdtok_pkg;

    localparam int POS_W   = 16;
    localparam int FIELD_W = 16;
    localparam int MODE_W  = 4;

    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

    localparam logic [1:0] KIND_HEADING = 2'd0;
    localparam logic [1:0] KIND_LIST    = 2'd1;
    localparam logic [1:0] KIND_RULE    = 2'd2;
    localparam logic [1:0] KIND_PARA    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_LINE_START  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_HASHES      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_HEAD_SPACES = 4'd2;
    localparam logic [MODE_W-1:0] MODE_HEAD_TEXT   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DASH1       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DASH2       = 4'd5;
    localparam logic [MODE_W-1:0] MODE_RULE_TAIL   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LIST_TEXT   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PARA_TEXT   = 4'd8;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  start;
        logic [7:0]        hash;
    } st_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         level;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic               done;
    } res_t;

    // positions wider than the result field report as all ones
    function automatic logic [FIELD_W-1:0] clamp_field(input logic [POS_W-1:0] v);
        logic [POS_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        if (w > {{POS_W{1'b0}}, FIELD_MAX}) begin
            return FIELD_MAX;
        end
        return w[FIELD_W-1:0];
    endfunction

    function automatic res_t make_result(input logic [1:0] kind, input logic [7:0] hash,
                                         input logic [POS_W-1:0] start,
                                         input logic [POS_W-1:0] stop);
        res_t r;
        logic [POS_W-1:0] len;
        len      = (stop >= start) ? (stop - start) : '0;
        r.kind   = kind;
        r.level  = (kind == KIND_HEADING) ? hash : 8'd0;
        r.offset = clamp_field(start);
        r.length = clamp_field(len);
        r.done   = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/mdtok_step.sv]
module mdtok_step (
    input  mdtok_pkg::st_t  st,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    output mdtok_pkg::st_t  st_next,
    output logic            res_valid,
    output mdtok_pkg::res_t res
);
    import mdtok_pkg::*;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] nxt;
    logic [1:0]       r_kind;
    logic [POS_W-1:0] r_start;
    logic [POS_W-1:0] r_stop;
    logic             hit;
    st_t              s;

    always_comb begin
        pos     = st.pos;
        nxt     = (pos == POS_MAX) ? pos : pos + 1'b1;
        s       = st;
        hit     = 1'b0;
        r_kind  = KIND_PARA;
        r_start = st.start;
        r_stop  = pos;

        case (st.mode)
            MODE_HASHES: begin
                if (text_byte == CH_HASH) begin
                    if (st.hash != 8'hFF) begin
                        s.hash = st.hash + 8'd1;
                    end
                end else if (text_byte == CH_SPACE) begin
                    s.mode = MODE_HEAD_SPACES;
                end else if (text_byte == CH_NL) begin
                    hit     = 1'b1;
                    r_kind  = KIND_HEADING;
                    r_start = pos;
                    s.mode  = MODE_LINE_START;
                end else begin
                    s.start = pos;
                    s.mode  = MODE_HEAD_TEXT;
                end
            end
            MODE_HEAD_SPACES: begin
                if (text_byte == CH_NL) begin
                    hit     = 1'b1;
                    r_kind  = KIND_HEADING;
                    r_start = pos;
                    s.mode  = MODE_LINE_START;
                end else if (text_byte != CH_SPACE) begin
                    s.start = pos;
                    s.mode  = MODE_HEAD_TEXT;
                end
            end
            MODE_HEAD_TEXT, MODE_LIST_TEXT, MODE_PARA_TEXT: begin
                if (text_byte == CH_NL) begin
                    hit    = 1'b1;
                    r_kind = (st.mode == MODE_HEAD_TEXT) ? KIND_HEADING :
                             (st.mode == MODE_LIST_TEXT) ? KIND_LIST : KIND_PARA;
                    s.mode = MODE_LINE_START;
                end
            end
            MODE_DASH1: begin
                if (text_byte == CH_SPACE) begin
                    s.start = nxt;
                    s.mode  = MODE_LIST_TEXT;
                end else if (text_byte == CH_DASH) begin
                    s.mode = MODE_DASH2;
                end else if (text_byte == CH_NL) begin
                    hit    = 1'b1;
                    s.mode = MODE_LINE_START;
                end else begin
                    s.mode = MODE_PARA_TEXT;
                end
            end
            MODE_DASH2: begin
                if (text_byte == CH_DASH) begin
                    hit    = 1'b1;
                    r_kind = KIND_RULE;
                    r_stop = st.start;
                    s.mode = MODE_RULE_TAIL;
                end else if (text_byte == CH_NL) begin
                    hit    = 1'b1;
                    s.mode = MODE_LINE_START;
                end else begin
                    s.mode = MODE_PARA_TEXT;
                end
            end
            default: begin
                // line start, rule tail (unless another dash) and unused codes
                if (!(st.mode == MODE_RULE_TAIL && text_byte == CH_DASH)) begin
                    if (text_byte == CH_HASH) begin
                        s.mode  = MODE_HASHES;
                        s.hash  = 8'd1;
                        s.start = pos;
                    end else if (text_byte == CH_DASH) begin
                        s.mode  = MODE_DASH1;
                        s.start = pos;
                    end else if (text_byte == CH_NL) begin
                        s.mode = MODE_LINE_START;
                    end else begin
                        s.mode  = MODE_PARA_TEXT;
                        s.start = pos;
                    end
                end
            end
        endcase

        s.pos = nxt;

        // end of text flushes an open token
        if (final_byte && !hit) begin
            case (s.mode)
                MODE_HASHES, MODE_HEAD_SPACES: begin
                    hit     = 1'b1;
                    r_kind  = KIND_HEADING;
                    r_start = nxt;
                    r_stop  = nxt;
                end
                MODE_HEAD_TEXT: begin
                    hit     = 1'b1;
                    r_kind  = KIND_HEADING;
                    r_start = s.start;
                    r_stop  = nxt;
                end
                MODE_LIST_TEXT: begin
                    hit     = 1'b1;
                    r_kind  = KIND_LIST;
                    r_start = s.start;
                    r_stop  = nxt;
                end
                MODE_PARA_TEXT, MODE_DASH1, MODE_DASH2: begin
                    hit     = 1'b1;
                    r_kind  = KIND_PARA;
                    r_start = s.start;
                    r_stop  = nxt;
                end
                default: begin
                    hit = hit;
                end
            endcase
        end

        res       = make_result(r_kind, s.hash, r_start, r_stop);
        res.done  = final_byte;
        res_valid = hit;

        if (final_byte) begin
            s.mode  = MODE_LINE_START;
            s.pos   = '0;
            s.start = '0;
            s.hash  = 8'd0;
        end
        st_next = s;
    end

endmodule

[hw/rtl/mdtok_outbuf.sv]
module mdtok_outbuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  mdtok_pkg::res_t in_res,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output mdtok_pkg::res_t out_res
);
    import mdtok_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : in_res;
        end else if (in_valid) begin
            skid_reg <= in_res;
        end
    end

    // only one result per byte, so a free skid slot is enough to take a byte
    assign space_ok  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

[hw/rtl/markdown_line_tokenizer_core.sv]
// markdown line tokenizer core
// input channel s_: one text byte per transfer, s_final_byte marks the last
// byte of a text; after it the next byte starts a fresh text at position 0
// result channel m_: one token per transfer (kind, heading level, text
// offset and length, stream_done on the token flushed by the final byte)
// a byte produces zero or one token; the token is registered in the
// output buffer before it appears on m_, after the transfer of the byte
// that closes it (newline, third dash of a rule, or final byte)
// throughput: one byte per cycle while s_ready is high, set by the
// combinational mode update held in the state registers below
// a two-entry output buffer (main and skid register) lets bytes keep
// flowing while m_ready is low until a second token is waiting; s_ready
// drops only once both entries hold tokens, and rises again in the cycle
// after the receiver drains one
// reset (aresetn low, synchronous) returns the scanner to line start at
// position 0 and empties the output buffer
`include "markdown_line_tokenizer_core_defines.svh"

module markdown_line_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [7:0]  m_heading_level,
    output logic [15:0] m_text_offset,
    output logic [15:0] m_text_length,
    output logic        m_stream_done
);
    import mdtok_pkg::*;

    st_t  st_reg;
    st_t  st_next;
    logic res_valid;
    res_t res;
    res_t out_res;
    logic space_ok;
    logic take;

    assign s_ready = space_ok;
    assign take    = s_valid && s_ready;

    // scanner state: mode, next byte position, token text start, hash count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode  <= MODE_LINE_START;
            st_reg.pos   <= '0;
            st_reg.start <= '0;
            st_reg.hash  <= 8'd0;
        end else if (take) begin
            st_reg <= st_next;
        end
    end

    // per-byte classification and token assembly
    mdtok_step u_step (
        .st         (st_reg),
        .text_byte  (s_text_byte),
        .final_byte (s_final_byte),
        .st_next    (st_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register with skid slot
    mdtok_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (take && res_valid),
        .in_res    (res),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_token_kind    = out_res.kind;
    assign m_heading_level = out_res.level;
    assign m_text_offset   = out_res.offset;
    assign m_text_length   = out_res.length;
    assign m_stream_done   = out_res.done;

    // input back-pressure only when the result register is occupied
    `MDTOK_ASSERT_ALWAYS(a_stall_needs_result, s_ready || m_valid, "stall without pending result")
    // final byte rewinds the position counter
    `MDTOK_ASSERT_NEXT(a_final_rewinds, take && s_final_byte, st_reg.pos == '0, "pos not cleared")
    // token text never starts beyond the next byte position
    `MDTOK_ASSERT_ALWAYS(a_start_order, st_reg.start <= st_reg.pos, "text start ahead of position")

endmodule

[tb/markdown_line_tokenizer_core_tb.sv]
`timescale 1ns / 1ps

module markdown_line_tokenizer_core_tb;
    import mdtok_pkg::*;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_MAX     = 10;

    // traffic phases, each tag travels with its byte
    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH_GAPS,
        PH_PRESSURE
    } phase_e;

    typedef enum logic [2:0] {
        LN_HEADING,
        LN_LIST,
        LN_RULE,
        LN_PARA,
        LN_SHORT_DASH,
        LN_BLANK,
        LN_NOISE
    } line_kind_e;

    typedef struct packed {
        logic [7:0] text;
        logic       fin;
        phase_e     phase;
    } text_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  level;
        logic [15:0] offset;
        logic [15:0] length;
        logic        done;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_token_kind;
    logic [7:0]  m_heading_level;
    logic [15:0] m_text_offset;
    logic [15:0] m_text_length;
    logic        m_stream_done;

    markdown_line_tokenizer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_final_byte    (s_final_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_heading_level (m_heading_level),
        .m_text_offset   (m_text_offset),
        .m_text_length   (m_text_length),
        .m_stream_done   (m_stream_done)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    text_item_t text_queue[$];     // bytes still to be offered
    token_t     pending_tokens[$]; // tokens predicted but not yet seen
    logic [7:0] line_buf[$];       // scratch for one generated line

    phase_e drv_phase = PH_STEADY; // phase of the byte currently offered
    bit     byte_taken = 1'b0;     // transfer on s_ at the last rising edge
    bit     holding = 1'b0;        // long receiver hold-off in progress
    int     mismatches = 0;
    int     cycle_count = 0;

    // scanner state mirrored from the block
    logic [MODE_W-1:0] scan_st;
    logic [15:0]       next_pos;
    logic [15:0]       tok_first;
    logic [7:0]        hashes;

    // ------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------

    function automatic token_t form_token(input logic [1:0] kind, input logic [15:0] first,
                                          input logic [15:0] stop);
        token_t t;
        t.kind   = kind;
        t.level  = (kind == KIND_HEADING) ? hashes : 8'd0;
        t.offset = first;
        t.length = (stop >= first) ? stop - first : 16'd0;
        t.done   = 1'b0;
        return t;
    endfunction

    // first byte of a token decides its kind
    function automatic void open_token(input logic [7:0] c, input logic [15:0] p);
        if (c == CH_HASH) begin
            scan_st   = MODE_HASHES;
            hashes    = 8'd1;
            tok_first = p;
        end else if (c == CH_DASH) begin
            scan_st   = MODE_DASH1;
            tok_first = p;
        end else if (c == CH_NL) begin
            scan_st = MODE_LINE_START;
        end else begin
            scan_st   = MODE_PARA_TEXT;
            tok_first = p;
        end
    endfunction

    function automatic void clear_scanner();
        scan_st   = MODE_LINE_START;
        next_pos  = 16'd0;
        tok_first = 16'd0;
        hashes    = 8'd0;
    endfunction

    task automatic tokenize_byte(input logic [7:0] c, input logic fin,
                                 output bit emitted, output token_t tok);
        logic [15:0] p;
        logic [15:0] p_next;
        logic [1:0]  kind;
        p       = next_pos;
        p_next  = (p == POS_MAX) ? p : p + 16'd1;
        emitted = 1'b0;
        tok     = '0;
        case (scan_st)
            MODE_HASHES: begin
                if (c == CH_HASH) begin
                    if (hashes != 8'd255) hashes = hashes + 8'd1;
                end else if (c == CH_SPACE) begin
                    scan_st = MODE_HEAD_SPACES;
                end else if (c == CH_NL) begin
                    tok     = form_token(KIND_HEADING, p, p);
                    emitted = 1'b1;
                    scan_st = MODE_LINE_START;
                end else begin
                    tok_first = p;
                    scan_st   = MODE_HEAD_TEXT;
                end
            end
            MODE_HEAD_SPACES: begin
                if (c == CH_NL) begin
                    tok     = form_token(KIND_HEADING, p, p);
                    emitted = 1'b1;
                    scan_st = MODE_LINE_START;
                end else if (c != CH_SPACE) begin
                    tok_first = p;
                    scan_st   = MODE_HEAD_TEXT;
                end
            end
            MODE_HEAD_TEXT, MODE_LIST_TEXT, MODE_PARA_TEXT: begin
                if (c == CH_NL) begin
                    kind = (scan_st == MODE_HEAD_TEXT) ? KIND_HEADING :
                           (scan_st == MODE_LIST_TEXT) ? KIND_LIST : KIND_PARA;
                    tok     = form_token(kind, tok_first, p);
                    emitted = 1'b1;
                    scan_st = MODE_LINE_START;
                end
            end
            MODE_DASH1: begin
                if (c == CH_SPACE) begin
                    tok_first = p_next;
                    scan_st   = MODE_LIST_TEXT;
                end else if (c == CH_DASH) begin
                    scan_st = MODE_DASH2;
                end else if (c == CH_NL) begin
                    tok     = form_token(KIND_PARA, tok_first, p);
                    emitted = 1'b1;
                    scan_st = MODE_LINE_START;
                end else begin
                    scan_st = MODE_PARA_TEXT;
                end
            end
            MODE_DASH2: begin
                if (c == CH_DASH) begin
                    // third dash: the rule goes out straight away
                    tok     = form_token(KIND_RULE, tok_first, tok_first);
                    emitted = 1'b1;
                    scan_st = MODE_RULE_TAIL;
                end else if (c == CH_NL) begin
                    tok     = form_token(KIND_PARA, tok_first, p);
                    emitted = 1'b1;
                    scan_st = MODE_LINE_START;
                end else begin
                    scan_st = MODE_PARA_TEXT;
                end
            end
            MODE_RULE_TAIL: begin
                if (c != CH_DASH) open_token(c, p);
            end
            default: open_token(c, p);
        endcase

        next_pos = p_next;

        if (fin) begin
            // final byte flushes whatever token is still open
            if (!emitted) begin
                case (scan_st)
                    MODE_HASHES, MODE_HEAD_SPACES: begin
                        tok     = form_token(KIND_HEADING, p_next, p_next);
                        emitted = 1'b1;
                    end
                    MODE_HEAD_TEXT: begin
                        tok     = form_token(KIND_HEADING, tok_first, p_next);
                        emitted = 1'b1;
                    end
                    MODE_LIST_TEXT: begin
                        tok     = form_token(KIND_LIST, tok_first, p_next);
                        emitted = 1'b1;
                    end
                    MODE_PARA_TEXT, MODE_DASH1, MODE_DASH2: begin
                        tok     = form_token(KIND_PARA, tok_first, p_next);
                        emitted = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (emitted) tok.done = 1'b1;
            clear_scanner();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0:       return CH_HASH;
            1:       return CH_DASH;
            2:       return CH_SPACE;
            3:       return CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin, input phase_e ph);
        text_item_t it;
        it.text  = b;
        it.fin   = fin;
        it.phase = ph;
        text_queue.push_back(it);
    endtask

    task automatic push_text(input string s, input logic fin, input phase_e ph);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], fin && (i == s.len() - 1), ph);
    endtask

    task automatic add_text(input int n);
        for (int i = 0; i < n; i++) line_buf.push_back(text_char());
    endtask

    // one well-formed line (or a noise burst) into line_buf
    task automatic make_line();
        int         pick;
        int         n;
        line_kind_e lk;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        lk   = (pick < 22) ? LN_HEADING :
               (pick < 40) ? LN_LIST :
               (pick < 55) ? LN_RULE :
               (pick < 72) ? LN_PARA :
               (pick < 84) ? LN_SHORT_DASH :
               (pick < 90) ? LN_BLANK : LN_NOISE;
        line_buf.delete();
        case (lk)
            LN_HEADING: begin
                // now and then a long run, which can saturate the level
                n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262)
                                                 : $urandom_range(1, 6);
                repeat (n) line_buf.push_back(CH_HASH);
                repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
                add_text($urandom_range(0, 10));
                line_buf.push_back(CH_NL);
            end
            LN_LIST: begin
                line_buf.push_back(CH_DASH);
                line_buf.push_back(CH_SPACE);
                add_text($urandom_range(0, 10));
                line_buf.push_back(CH_NL);
            end
            LN_RULE: begin
                repeat ($urandom_range(3, 6)) line_buf.push_back(CH_DASH);
                // without newline the next line is classified right after
                if ($urandom_range(0, 1) == 0) line_buf.push_back(CH_NL);
            end
            LN_PARA: begin
                do c = text_char(); while (c == CH_HASH || c == CH_DASH || c == CH_NL);
                line_buf.push_back(c);
                add_text($urandom_range(0, 12));
                line_buf.push_back(CH_NL);
            end
            LN_SHORT_DASH: begin
                repeat ($urandom_range(1, 2)) line_buf.push_back(CH_DASH);
                if ($urandom_range(0, 1) == 0) begin
                    do c = text_char(); while (c == CH_SPACE || c == CH_DASH || c == CH_NL);
                    line_buf.push_back(c);
                    add_text($urandom_range(0, 6));
                end
                line_buf.push_back(CH_NL);
            end
            LN_BLANK: line_buf.push_back(CH_NL);
            default: begin
                repeat ($urandom_range(1, 8)) line_buf.push_back(noise_char());
            end
        endcase
    endtask

    // random lines until the phase has its share of bytes
    task automatic add_random_lines(input phase_e ph, input int budget);
        int count;
        int cut;
        count = 0;
        while (count < budget) begin
            make_line();
            cut = line_buf.size();
            case ($urandom_range(0, 9))
                // text ends at a random byte of the line
                0: begin
                    cut = $urandom_range(1, line_buf.size());
                    for (int i = 0; i < cut; i++) push_byte(line_buf[i], i == cut - 1, ph);
                end
                // text ends on the line's last byte
                1: for (int i = 0; i < cut; i++) push_byte(line_buf[i], i == cut - 1, ph);
                default: for (int i = 0; i < cut; i++) push_byte(line_buf[i], 1'b0, ph);
            endcase
            count += cut;
        end
    endtask

    task automatic add_directed();
        push_text("#\n", 1'b0, PH_STEADY);          // heading with no text at newline
        push_text("## x\n", 1'b0, PH_STEADY);
        push_text("- a\n", 1'b0, PH_STEADY);
        push_text("----z\n", 1'b0, PH_STEADY);      // rule absorbs dashes, then paragraph
        push_text("-\n", 1'b0, PH_STEADY);          // short dash runs end as paragraphs
        push_text("--q\n", 1'b0, PH_STEADY);
        push_byte(8'hFF, 1'b0, PH_STEADY);
        push_byte(8'h00, 1'b1, PH_STEADY);          // zero byte is plain text
        push_text("- ", 1'b1, PH_STEADY);           // list cut off after its space
        push_text("#", 1'b1, PH_STEADY);            // heading cut off before text
        push_text("--", 1'b1, PH_STEADY);
    endtask

    // long heading run: the level saturates
    task automatic add_long_texts();
        repeat (260) push_byte(CH_HASH, 1'b0, PH_STEADY);
        push_text(" h\n", 1'b1, PH_STEADY);
        push_byte(8'h70, 1'b0, PH_STEADY);
        push_text("\n# t\n- u\n---p", 1'b1, PH_STEADY);
    endtask

    // ------------------------------------------------------------------
    // idling per phase
    // ------------------------------------------------------------------

    function automatic bit sender_idles(input phase_e ph);
        case (ph)
            PH_SEND_GAPS: return $urandom_range(0, 99) < 58;
            PH_BOTH_GAPS: return $urandom_range(0, 99) < 32;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls(input phase_e ph);
        case (ph)
            PH_RECV_STALLS: return $urandom_range(0, 99) < 58;
            PH_BOTH_GAPS:   return $urandom_range(0, 99) < 32;
            default:        return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: new byte on the falling edge once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || byte_taken)) begin
            if (text_queue.size() != 0 && !sender_idles(text_queue[0].phase)) begin
                s_valid      <= 1'b1;
                s_text_byte  <= text_queue[0].text;
                s_final_byte <= text_queue[0].fin;
                drv_phase    <= text_queue[0].phase;
                void'(text_queue.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver side ready, random stalls plus the long hold-off
    always @(negedge aclk) begin
        if (aresetn) m_ready <= !holding && !receiver_stalls(drv_phase);
    end

    // hold-off counted here so the sender keeps offering into a full block
    initial begin : receiver_holdoff
        wait (drv_phase == PH_PRESSURE);
        @(posedge aclk);
        holding = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
        holding = 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: predict on each byte transfer, check each token transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        bit     hit;
        token_t want;
        token_t got;
        byte_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                byte_taken = 1'b1;
                tokenize_byte(s_text_byte, s_final_byte, hit, want);
                if (hit) pending_tokens.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.kind   = m_token_kind;
                got.level  = m_heading_level;
                got.offset = m_text_offset;
                got.length = m_text_length;
                got.done   = m_stream_done;
                if (pending_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected token: kind %0d level %0d off %0d len %0d done %0d",
                                 got.kind, got.level, got.offset, got.length, got.done);
                end else begin
                    want = pending_tokens.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("mismatch: expected kind %0d level %0d off %0d len %0d done %0d",
                                     want.kind, want.level, want.offset, want.length, want.done);
                            $display("          got      kind %0d level %0d off %0d len %0d done %0d",
                                     got.kind, got.level, got.offset, got.length, got.done);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_text_byte  = 8'd0;
        s_final_byte = 1'b0;
        m_ready      = 1'b0;
        clear_scanner();

        add_directed();
        add_long_texts();
        add_random_lines(PH_STEADY, 80);
        add_random_lines(PH_SEND_GAPS, 80);
        add_random_lines(PH_RECV_STALLS, 80);
        add_random_lines(PH_BOTH_GAPS, 80);
        add_random_lines(PH_PRESSURE, 80);
        // quiet stretch so the run also ends without stalls
        add_random_lines(PH_STEADY, 40);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all bytes transferred, then all tokens drained
        while (text_queue.size() != 0 || s_valid) @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mdtok_pkg.sv
hw/rtl/mdtok_step.sv
hw/rtl/mdtok_outbuf.sv
hw/rtl/markdown_line_tokenizer_core.sv
tb/markdown_line_tokenizer_core_tb.sv
